// ===== hw/rtl/svc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed varint codec package
// Shared types, constants and small lookup functions for the controller,
// the datapath and the top level of the signed varint codec.
// ----------------------------------------------------------------------------
package svc_pkg;

  // Longest code in bytes.
  localparam int unsigned MaxBytes = 5;

  // Width of the collected-byte counter.
  localparam int unsigned CountW = 3;

  // Item kinds, shared by the input and the result side.
  typedef enum logic {
    KIND_ENC = 1'b0,
    KIND_DEC = 1'b1
  } kind_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_enc;  // Take a value and emit its first byte.
    logic step_enc;  // Emit the next byte of the value in flight.
    logic dec;       // Take one byte into the decoder.
  } svc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic more_first;  // The value at the input needs more than one byte.
    logic more_next;   // The byte about to go out is not the last one.
    logic dec_emit;    // The byte at the input completes a decode result.
  } svc_sts_t;

  // Bit position where the payload of a later byte lands in the decoder.
  function automatic logic [4:0] dec_shift(input logic [CountW-1:0] k);
    logic [4:0] s;
    begin
      case (k)
        3'd1:    s = 5'd6;
        3'd2:    s = 5'd13;
        3'd3:    s = 5'd20;
        3'd4:    s = 5'd27;
        default: s = 5'd0;
      endcase
      return s;
    end
  endfunction

  // Sign fill for a code that ended after k bytes; nothing is left to fill
  // once five bytes have covered all 32 bits.
  function automatic logic [31:0] fill_mask(input logic [CountW-1:0] k);
    logic [31:0] m;
    begin
      case (k)
        3'd1:    m = 32'hFFFF_FFC0;
        3'd2:    m = 32'hFFFF_E000;
        3'd3:    m = 32'hFFF0_0000;
        3'd4:    m = 32'hF800_0000;
        default: m = 32'h0000_0000;
      endcase
      return m;
    end
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/svc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed varint codec datapath
// Holds the encoder shift register, the decoder accumulator and the
// registered result beat. Acts on commands from the controller.
// ----------------------------------------------------------------------------
module svc_dp (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire svc_pkg::svc_cmd_t cmd_i,
  output svc_pkg::svc_sts_t     sts_o,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]       byte_in_i,
  output logic                  result_kind_o,
  output logic [7:0]            byte_out_o,
  output logic signed [31:0]    decoded_o,
  output logic                  too_long_o,
  output logic                  last_o
);

  // Encoder: value shifted past the bytes already sent.
  logic signed [31:0] enc_q, enc_d;

  // Decoder state.
  logic [31:0]                  acc_q, acc_d;
  logic [svc_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic                         sign_q, sign_d;

  // Result beat.
  logic                         rkind_q, rkind_d;
  logic [7:0]                   byte_q, byte_d;
  logic signed [31:0]           dec_q, dec_d;
  logic                         tl_q, tl_d;
  logic                         last_q, last_d;

  // Encoder terms for the first byte and for a later byte.
  logic signed [31:0] rest_first, rest_next;
  logic               more_first, more_next;

  // Decoder terms.
  logic [svc_pkg::CountW-1:0]   k_eff, k_new;
  logic                         first_byte;
  logic                         sign_nxt;
  logic [31:0]                  acc_nxt;
  logic [31:0]                  dec_val;
  logic                         too_long;
  logic                         dec_emit;

  // Encoder: an arithmetic shift drops the bits already sent; more bytes
  // follow while the rest is not pure sign.
  always_comb begin
    rest_first = value_i >>> 6;
    more_first = (rest_first != {32{value_i[31]}});
    rest_next  = enc_q >>> 7;
    more_next  = (rest_next != {32{enc_q[31]}});
  end

  // Decoder: merge one byte into the accumulator and build the result.
  always_comb begin
    k_eff      = (cnt_q >= svc_pkg::CountW'(svc_pkg::MaxBytes)) ? '0 : cnt_q;
    first_byte = (k_eff == '0);
    k_new      = k_eff + svc_pkg::CountW'(1);
    if (first_byte) begin
      sign_nxt = byte_in_i[6];
      acc_nxt  = {26'd0, byte_in_i[5:0]};
    end else begin
      sign_nxt = sign_q;
      acc_nxt  = acc_q | ({25'd0, byte_in_i[6:0]} << svc_pkg::dec_shift(k_eff));
    end
    too_long = byte_in_i[7] && (k_new == svc_pkg::CountW'(svc_pkg::MaxBytes));
    dec_emit = !byte_in_i[7] || too_long;
    dec_val  = acc_nxt | (sign_nxt ? svc_pkg::fill_mask(k_new) : 32'd0);
  end

  assign sts_o.more_first = more_first;
  assign sts_o.more_next  = more_next;
  assign sts_o.dec_emit   = dec_emit;

  // Next values of the working registers and of the result beat.
  always_comb begin
    enc_d   = enc_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    sign_d  = sign_q;
    rkind_d = rkind_q;
    byte_d  = byte_q;
    dec_d   = dec_q;
    tl_d    = tl_q;
    last_d  = last_q;
    if (cmd_i.load_enc) begin
      enc_d   = rest_first;
      rkind_d = svc_pkg::KIND_ENC;
      byte_d  = {more_first, value_i[31], value_i[5:0]};
      dec_d   = '0;
      tl_d    = 1'b0;
      last_d  = !more_first;
    end else if (cmd_i.step_enc) begin
      enc_d   = rest_next;
      rkind_d = svc_pkg::KIND_ENC;
      byte_d  = {more_next, enc_q[6:0]};
      dec_d   = '0;
      tl_d    = 1'b0;
      last_d  = !more_next;
    end else if (cmd_i.dec) begin
      if (dec_emit) begin
        // A finished or overlong code restarts the decoder.
        acc_d   = '0;
        cnt_d   = '0;
        sign_d  = 1'b0;
        rkind_d = svc_pkg::KIND_DEC;
        byte_d  = '0;
        dec_d   = too_long ? 32'sd0 : $signed(dec_val);
        tl_d    = too_long;
        last_d  = 1'b1;
      end else begin
        acc_d  = acc_nxt;
        cnt_d  = k_new;
        sign_d = sign_nxt;
      end
    end
  end

  // Decoder state is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      sign_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      sign_q <= sign_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    enc_q   <= enc_d;
    rkind_q <= rkind_d;
    byte_q  <= byte_d;
    dec_q   <= dec_d;
    tl_q    <= tl_d;
    last_q  <= last_d;
  end

  assign result_kind_o = rkind_q;
  assign byte_out_o    = byte_q;
  assign decoded_o     = dec_q;
  assign too_long_o    = tl_q;
  assign last_o        = last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/svc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed varint codec controller
// Sequences the bytes of an encode item and owns the handshakes of both
// channels and the valid flag of the result register.
// ----------------------------------------------------------------------------
module svc_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire logic           kind_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output svc_pkg::svc_cmd_t   cmd_o,
  input  wire svc_pkg::svc_sts_t sts_i
);

  typedef enum logic {
    ST_IDLE,
    ST_ENC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;
  logic   emit;

  // The result register can take a beat when empty or being drained.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // Commands to the datapath.
  always_comb begin
    cmd_o.load_enc = accept && (kind_i == svc_pkg::KIND_ENC);
    cmd_o.dec      = accept && (kind_i == svc_pkg::KIND_DEC);
    cmd_o.step_enc = (state_q == ST_ENC) && slot_free;
  end

  assign emit = cmd_o.load_enc || cmd_o.step_enc || (cmd_o.dec && sts_i.dec_emit);

  // Next state and result valid flag.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load_enc && sts_i.more_first) begin
          state_d = ST_ENC;
        end
      end
      ST_ENC: begin
        if (cmd_o.step_enc && !sts_i.more_next) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/signed_varint_codec.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Signed varint codec
// Encodes signed 32-bit integers into one to five bytes and decodes such
// byte streams back, one byte per decode item.
// ----------------------------------------------------------------------------
// An encode item yields one to five output bytes, the controller stepping
// the encoder shift register one byte per cycle while the result register
// is free; the next item is taken once the controller is idle again and
// the result register is free. A decode item is handled when it is accepted.
// Every result leaves through a single result register, so a stalled
// output holds off new items until that beat is taken. Decoder state
// survives encode items, so a partial code may be interleaved with encodes.
module signed_varint_codec (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               kind_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [7:0]         byte_in_i,
  output logic                    out_valid_o,
  input  wire                     out_ready_i,
  output logic                    result_kind_o,
  output logic [7:0]              byte_out_o,
  output logic signed [31:0]      decoded_o,
  output logic                    too_long_o,
  output logic                    last_o
);

  svc_pkg::svc_cmd_t cmd;
  svc_pkg::svc_sts_t sts;

  // Sequencing and handshakes.
  svc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Encoder, decoder and result register.
  svc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .byte_in_i    (byte_in_i),
    .result_kind_o(result_kind_o),
    .byte_out_o   (byte_out_o),
    .decoded_o    (decoded_o),
    .too_long_o   (too_long_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire
